// ===== src/x256_pkg.sv =====
// shared types, constants and the state update of the xoshiro256** generator
// used by xoshiro256ss_prng_with_jump; no dependencies
package x256_pkg;

  typedef logic [3:0][63:0] state_t;

  typedef enum logic [1:0] {
    OP_NEXT = 2'd0,
    OP_SEED = 2'd1,
    OP_JUMP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_SM_ADD,
    ST_SM_MUL1,
    ST_SM_MUL2,
    ST_IDLE,
    ST_NX_MUL1,
    ST_NX_MUL2,
    ST_NX_HOLD,
    ST_JUMP
  } fsm_e;

  // splitmix64 constants
  localparam logic [63:0] SmGolden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SmMix1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SmMix2   = 64'h94d049bb133111eb;

  // scrambler multipliers
  localparam logic [63:0] ScrMul5 = 64'd5;
  localparam logic [63:0] ScrMul9 = 64'd9;

  localparam logic [7:0] JumpLastStep = 8'hff;
  localparam logic [1:0] SeedLastWord = 2'd3;

  // jump polynomials, word 0 in the low bits
  localparam logic [255:0] JumpPoly [2] = '{
    {64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
     64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba},
    {64'h39109bb02acbe635, 64'h77710069854ee241,
     64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf}
  };

  // one generator step
  function automatic state_t advance(input state_t s);
    state_t r;
    logic [63:0] t;
    t    = s[1] << 17;
    r    = s;
    r[2] = s[2] ^ s[0];
    r[3] = s[3] ^ s[1];
    r[1] = s[1] ^ r[2];
    r[0] = s[0] ^ r[3];
    r[2] = r[2] ^ t;
    r[3] = {r[3][18:0], r[3][63:19]};
    return r;
  endfunction

endpackage

// ===== src/x256_mul.sv =====
// iterative 64x64 multiplier keeping the low 64 bits of the product
// one 32x32 partial product per cycle; no dependencies
module x256_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] op_x, op_y;
  logic [63:0] pp;

  // lo*lo, then lo*hi and hi*lo shifted into the upper half
  always_comb begin
    op_x = (cnt_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    op_y = (cnt_q == 2'd1) ? b_q[63:32] : b_q[31:0];
  end

  assign pp = op_x * op_y;

  always_comb begin
    if (cnt_q == 2'd0) begin
      acc_d = pp;
    end else begin
      acc_d = acc_q + {pp[31:0], 32'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 2'd2);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 2'd3))
    else $error("multiplier step count out of range");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 2'd2 && !start_i) |=> (done_q && !busy_q))
    else $error("multiplier did not finish after its last step");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("multiplier done held longer than one cycle");
`endif

endmodule

// ===== src/xoshiro256ss_prng_with_jump.sv =====
// xoshiro256** generator with splitmix64 reseed and jump-ahead
// depends on x256_pkg and x256_mul
//
//  channel  dir  tdata             tuser                         meaning
//  s_axis   in   [63:0] seed_value [1:0] opcode [2] jump_select  one command per beat
//  m_axis   out  [63:0] random_val -                             one beat per next command
//
// next: two passes through the shared 3-step multiplier (s1*5, then rotl(.,7)*9), the product
// loaded into the m_axis register; a new command is taken once the block is back in idle
// reseed: four splitmix64 draws, each an add followed by two multiplier passes
// jump: one polynomial bit and one generator step per cycle, over all bits of the selected polynomial
// after reset the block runs the seed-zero expansion with s_axis_tready low
// a full output register does not block commands; a finished next waits until the beat is taken
module xoshiro256ss_prng_with_jump (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] seed_value
  input  logic [2:0]  s_axis_tuser,   // [1:0] opcode, [2] jump_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [63:0] random_value
);

  x256_pkg::fsm_e   state_q, state_d;
  x256_pkg::state_t words_q, words_d;
  x256_pkg::state_t jacc_q, jacc_d;
  x256_pkg::state_t words_adv;
  logic [63:0]      ctr_q, ctr_d, ctr_inc;
  logic [1:0]       idx_q, idx_d;
  logic [7:0]       step_q, step_d;
  logic             sel_q, sel_d;
  logic [63:0]      out_data_q, out_data_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc;
  logic [1:0]       in_op;
  logic             out_free;
  logic             out_load;
  logic             poly_bit;

  // shared multiplier
  logic             mul_start;
  logic [63:0]      mul_a, mul_b, mul_p;
  logic             mul_done;

  x256_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  assign in_op     = s_axis_tuser[1:0];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign ctr_inc   = ctr_q + x256_pkg::SmGolden;
  assign words_adv = x256_pkg::advance(words_q);
  assign poly_bit  = x256_pkg::JumpPoly[sel_q][step_q];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      x256_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            x256_pkg::OP_NEXT: state_d = x256_pkg::ST_NX_MUL1;
            x256_pkg::OP_SEED: state_d = x256_pkg::ST_SM_ADD;
            x256_pkg::OP_JUMP: state_d = x256_pkg::ST_JUMP;
            default:           state_d = x256_pkg::ST_IDLE;
          endcase
        end
      end
      x256_pkg::ST_SM_ADD:  state_d = x256_pkg::ST_SM_MUL1;
      x256_pkg::ST_SM_MUL1: begin
        if (mul_done) state_d = x256_pkg::ST_SM_MUL2;
      end
      x256_pkg::ST_SM_MUL2: begin
        if (mul_done) begin
          state_d = (idx_q == x256_pkg::SeedLastWord) ? x256_pkg::ST_IDLE
                                                      : x256_pkg::ST_SM_ADD;
        end
      end
      x256_pkg::ST_NX_MUL1: begin
        if (mul_done) state_d = x256_pkg::ST_NX_MUL2;
      end
      x256_pkg::ST_NX_MUL2: begin
        if (mul_done) state_d = out_free ? x256_pkg::ST_IDLE : x256_pkg::ST_NX_HOLD;
      end
      x256_pkg::ST_NX_HOLD: begin
        if (out_free) state_d = x256_pkg::ST_IDLE;
      end
      x256_pkg::ST_JUMP: begin
        if (step_q == x256_pkg::JumpLastStep) state_d = x256_pkg::ST_IDLE;
      end
      default: state_d = x256_pkg::ST_IDLE;
    endcase
  end

  // control outputs: handshake and multiplier issue
  always_comb begin
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    mul_a         = mul_p;
    mul_b         = x256_pkg::ScrMul9;
    out_load      = 1'b0;
    unique case (state_q)
      x256_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        // scrambler first pass uses s1 before the state advances
        mul_start = in_acc && (in_op == x256_pkg::OP_NEXT);
        mul_a     = words_q[1];
        mul_b     = x256_pkg::ScrMul5;
      end
      x256_pkg::ST_SM_ADD: begin
        mul_start = 1'b1;
        mul_a     = ctr_inc ^ (ctr_inc >> 30);
        mul_b     = x256_pkg::SmMix1;
      end
      x256_pkg::ST_SM_MUL1: begin
        mul_start = mul_done;
        mul_a     = mul_p ^ (mul_p >> 27);
        mul_b     = x256_pkg::SmMix2;
      end
      x256_pkg::ST_NX_MUL1: begin
        mul_start = mul_done;
        mul_a     = {mul_p[56:0], mul_p[63:57]};
        mul_b     = x256_pkg::ScrMul9;
      end
      x256_pkg::ST_NX_MUL2: out_load = mul_done && out_free;
      x256_pkg::ST_NX_HOLD: out_load = out_free;
      x256_pkg::ST_SM_MUL2,
      x256_pkg::ST_JUMP: ;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    words_d     = words_q;
    jacc_d      = jacc_q;
    ctr_d       = ctr_q;
    idx_d       = idx_q;
    step_d      = step_q;
    sel_d       = sel_q;
    out_data_d  = out_load ? mul_p : out_data_q;
    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
    unique case (state_q)
      x256_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            x256_pkg::OP_NEXT: words_d = words_adv;
            x256_pkg::OP_SEED: begin
              ctr_d = s_axis_tdata;
              idx_d = 2'd0;
            end
            x256_pkg::OP_JUMP: begin
              jacc_d = '0;
              step_d = 8'd0;
              sel_d  = s_axis_tuser[2];
            end
            default: ;
          endcase
        end
      end
      x256_pkg::ST_SM_ADD: ctr_d = ctr_inc;
      x256_pkg::ST_SM_MUL2: begin
        if (mul_done) begin
          words_d[idx_q] = mul_p ^ (mul_p >> 31);
          idx_d          = idx_q + 2'd1;
        end
      end
      x256_pkg::ST_JUMP: begin
        // fold in the current state where the polynomial bit is set
        if (poly_bit) jacc_d = jacc_q ^ words_q;
        step_d  = step_q + 8'd1;
        words_d = (step_q == x256_pkg::JumpLastStep) ? jacc_d : words_adv;
      end
      x256_pkg::ST_SM_MUL1,
      x256_pkg::ST_NX_MUL1,
      x256_pkg::ST_NX_MUL2,
      x256_pkg::ST_NX_HOLD: ;
      default: ;
    endcase
  end

  // reset starts the seed-zero expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= x256_pkg::ST_SM_ADD;
      ctr_q       <= '0;
      idx_q       <= 2'd0;
      step_q      <= 8'd0;
      sel_q       <= 1'b0;
      jacc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      sel_q       <= sel_d;
      jacc_q      <= jacc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    words_q    <= words_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_next_enters_scrambler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == x256_pkg::OP_NEXT) |=> (state_q == x256_pkg::ST_NX_MUL1))
    else $error("accepted next did not start the scrambler");
  a_jump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == x256_pkg::ST_JUMP && step_q == x256_pkg::JumpLastStep)
      |=> (state_q == x256_pkg::ST_IDLE && step_q == 8'd0))
    else $error("jump walk did not end after its last bit");
  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == x256_pkg::ST_SM_MUL1 || state_q == x256_pkg::ST_SM_MUL2 ||
                  state_q == x256_pkg::ST_NX_MUL1 || state_q == x256_pkg::ST_NX_MUL2))
    else $error("multiplier finished outside a waiting state");
  a_hold_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == x256_pkg::ST_NX_HOLD) |-> out_valid_q)
    else $error("result held back while output register empty");
`endif

endmodule
